>>> rtl/rrpd_pkg.sv
`default_nettype none

package rrpd_pkg;

  // Field widths
  localparam int unsigned TS_W       = 32;
  localparam int unsigned CFG_W      = 12;
  localparam int unsigned CODE_OUT_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned HP_W       = 6;
  localparam int unsigned EXP_W      = 15;

  // Default code length
  localparam int unsigned CODE_BITS_DEF = 24;

  // Interval multiples of the unit pulse
  localparam int unsigned PREAMBLE_MULT = 6;
  localparam int unsigned LONG_MULT     = 3;
  localparam int unsigned SHORT_MULT    = 1;

  // Half-pair marks: first half sets a mark, second half adds to it
  localparam logic [HP_W-1:0] HP_LONG_MARK  = HP_W'(30);
  localparam logic [HP_W-1:0] HP_SHORT_MARK = HP_W'(10);
  localparam logic [HP_W-1:0] HP_LONG_INC   = HP_W'(3);
  localparam logic [HP_W-1:0] HP_SHORT_INC  = HP_W'(1);
  localparam logic [HP_W-1:0] HP_BIT_ZERO   = HP_W'(13);
  localparam logic [HP_W-1:0] HP_BIT_ONE    = HP_W'(31);

  // Register reset values
  localparam logic [CFG_W-1:0] PULSE_RST = CFG_W'(400);
  localparam logic [CFG_W-1:0] TOL_RST   = CFG_W'(200);

  // Input commands
  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOL   = CFG_IDX_W'(1);

  typedef struct packed {
    logic            cmd;
    logic [TS_W-1:0] timestamp_us;
  } in_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] pulse_us;
    logic [CFG_W-1:0] tolerance_us;
  } cfg_t;

  typedef struct packed {
    logic near_preamble;
    logic near_long;
    logic near_short;
  } match_t;

endpackage

`default_nettype wire

>>> rtl/rrpd_if.sv
`default_nettype none

// Edge and clear words into the decoder
interface rrpd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [rrpd_pkg::TS_W-1:0] timestamp_us;

  modport source (output valid, output cmd, output timestamp_us, input ready);
  modport sink   (input valid, input cmd, input timestamp_us, output ready);
endinterface

// Result words out of the decoder
interface rrpd_out_if;
  logic                            valid;
  logic                            ready;
  logic                            code_ready;
  logic [rrpd_pkg::CODE_OUT_W-1:0] code_value;

  modport source (output valid, output code_ready, output code_value, input ready);
  modport sink   (input valid, input code_ready, input code_value, output ready);
endinterface

// Register write channel
interface rrpd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rrpd_pkg::CFG_IDX_W-1:0] index;
  logic [rrpd_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rrpd_in_reg.sv
`default_nettype none

module rrpd_in_reg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  rrpd_in_if.sink           in_i,
  input  wire logic         take_i,
  output logic              valid_o,
  output rrpd_pkg::in_word_t word_o
);
  import rrpd_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q, word_d;
  logic     load;

  // Accept when empty or when the held word leaves this cycle
  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (load) begin
      valid_d = 1'b1;
      word_d  = '{cmd: in_i.cmd, timestamp_us: in_i.timestamp_us};
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

>>> rtl/rrpd_match.sv
`default_nettype none

module rrpd_match (
  input  wire logic [rrpd_pkg::TS_W-1:0] interval_i,
  input  wire rrpd_pkg::cfg_t            cfg_i,
  output rrpd_pkg::match_t               match_o
);
  import rrpd_pkg::*;

  logic [EXP_W-1:0] exp_preamble;
  logic [EXP_W-1:0] exp_long;
  logic [EXP_W-1:0] exp_short;

  // Strict window test: |interval - expected| < tolerance
  function automatic logic near_len(input logic [TS_W-1:0]  iv,
                                    input logic [EXP_W-1:0] expd,
                                    input logic [CFG_W-1:0] tol);
    logic [TS_W-1:0] e32;
    logic [TS_W-1:0] dev;
    e32 = TS_W'(expd);
    dev = (iv >= e32) ? (iv - e32) : (e32 - iv);
    return dev < TS_W'(tol);
  endfunction

  // Form the expected lengths
  assign exp_preamble = EXP_W'(cfg_i.pulse_us) * EXP_W'(PREAMBLE_MULT);
  assign exp_long     = EXP_W'(cfg_i.pulse_us) * EXP_W'(LONG_MULT);
  assign exp_short    = EXP_W'(cfg_i.pulse_us) * EXP_W'(SHORT_MULT);

  assign match_o.near_preamble = near_len(interval_i, exp_preamble, cfg_i.tolerance_us);
  assign match_o.near_long     = near_len(interval_i, exp_long, cfg_i.tolerance_us);
  assign match_o.near_short    = near_len(interval_i, exp_short, cfg_i.tolerance_us);

endmodule

`default_nettype wire

>>> rtl/rrpd_core.sv
`default_nettype none

module rrpd_core #(
  parameter int unsigned CODE_BITS = rrpd_pkg::CODE_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire rrpd_pkg::in_word_t        word_i,
  output logic                           take_o,
  output logic [rrpd_pkg::TS_W-1:0]      interval_o,
  input  wire rrpd_pkg::match_t          match_i,
  rrpd_out_if.source                     out_o
);
  import rrpd_pkg::*;

  localparam int unsigned BC_W = $clog2(CODE_BITS + 1);

  typedef enum logic [1:0] {
    PH_PREAMBLE,
    PH_FIRST,
    PH_SECOND,
    PH_HELD
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [TS_W-1:0]       last_edge_q, last_edge_d;
  logic [HP_W-1:0]       half_pair_q, half_pair_d;
  logic [BC_W-1:0]       bit_count_q, bit_count_d;
  logic [CODE_BITS-1:0]  shift_q, shift_d;
  logic                  out_valid_q, out_valid_d;
  logic                  code_ready_q, code_ready_d;
  logic [CODE_OUT_W-1:0] code_value_q, code_value_d;
  logic [HP_W-1:0]       hp_sum;
  logic                  fire;

  // Advance when the result register is free or drains this cycle
  assign take_o     = !out_valid_q || out_o.ready;
  assign fire       = valid_i && take_o;
  assign interval_o = word_i.timestamp_us - last_edge_q;
  assign hp_sum     = half_pair_q + (match_i.near_long ? HP_LONG_INC : HP_SHORT_INC);

  // Decode one word
  always_comb begin
    phase_d      = phase_q;
    last_edge_d  = last_edge_q;
    half_pair_d  = half_pair_q;
    bit_count_d  = bit_count_q;
    shift_d      = shift_q;
    out_valid_d  = out_valid_q;
    code_ready_d = code_ready_q;
    code_value_d = code_value_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      if (word_i.cmd == CMD_CLEAR) begin
        shift_d = '0;
        phase_d = PH_PREAMBLE;
      end else begin
        last_edge_d = word_i.timestamp_us;
        unique case (phase_q)
          PH_PREAMBLE: begin
            if (match_i.near_preamble) begin
              shift_d     = '0;
              bit_count_d = '0;
              phase_d     = PH_FIRST;
            end
          end
          PH_FIRST: begin
            if (match_i.near_long) begin
              half_pair_d = HP_LONG_MARK;
              phase_d     = PH_SECOND;
            end else if (match_i.near_short) begin
              half_pair_d = HP_SHORT_MARK;
              phase_d     = PH_SECOND;
            end else begin
              phase_d = PH_PREAMBLE;
            end
          end
          PH_SECOND: begin
            if (!match_i.near_long && !match_i.near_short) begin
              phase_d = PH_PREAMBLE;
            end else begin
              half_pair_d = hp_sum;
              if (hp_sum == HP_BIT_ZERO || hp_sum == HP_BIT_ONE) begin
                shift_d     = CODE_BITS'({shift_q, hp_sum == HP_BIT_ONE});
                bit_count_d = bit_count_q + 1'b1;
                phase_d     = (bit_count_d == BC_W'(CODE_BITS)) ? PH_HELD : PH_FIRST;
              end else begin
                phase_d = PH_PREAMBLE;
              end
            end
          end
          PH_HELD: begin
            phase_d = PH_HELD;
          end
          default: begin
            phase_d = PH_PREAMBLE;
          end
        endcase
      end
      out_valid_d  = 1'b1;
      code_ready_d = (phase_d == PH_HELD);
      code_value_d = CODE_OUT_W'(shift_d);
    end
  end

  // Hold state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_PREAMBLE;
      last_edge_q  <= '0;
      half_pair_q  <= '0;
      bit_count_q  <= '0;
      shift_q      <= '0;
      out_valid_q  <= 1'b0;
      code_ready_q <= 1'b0;
      code_value_q <= '0;
    end else begin
      phase_q      <= phase_d;
      last_edge_q  <= last_edge_d;
      half_pair_q  <= half_pair_d;
      bit_count_q  <= bit_count_d;
      shift_q      <= shift_d;
      out_valid_q  <= out_valid_d;
      code_ready_q <= code_ready_d;
      code_value_q <= code_value_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.code_ready = code_ready_q;
  assign out_o.code_value = code_value_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_count_q <= BC_W'(CODE_BITS))
    else $error("bit count ran past code length");

  a_second_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SECOND |-> (half_pair_q == HP_LONG_MARK || half_pair_q == HP_SHORT_MARK))
    else $error("second half entered without a first-half mark");

  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && word_i.cmd == CMD_EDGE && phase_q == PH_HELD)
      |=> (phase_q == PH_HELD && $stable(shift_q)))
    else $error("held code changed on an edge");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && word_i.cmd == CMD_CLEAR) |=> (phase_q == PH_PREAMBLE && shift_q == '0))
    else $error("clear did not rearm");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_valid_q && out_o.code_ready == (phase_q == PH_HELD)))
    else $error("result word missing or flag out of step with state");
`endif

endmodule

`default_nettype wire

>>> rtl/rf_remote_pulse_decoder_unit.sv
// RF remote pulse-width code decoder.
// Input channel in_i: one word per line edge (cmd = edge) carrying the
// microsecond timestamp of the edge, or a clear word (cmd = clear) that drops
// a held code and rearms the receiver for a new preamble.
// Output channel out_o: exactly one word per input word, in order, carrying
// code_ready (a full code is held) and code_value (the code bits so far).
// Register channel cfg_i: index 0 = unit pulse in us, 1 = tolerance in us;
// other indexes are ignored. Always ready; write only while idle.
// Throughput: one word per cycle while out_o.ready stays high. Each word
// passes an input register and then a result register; the interval
// compares and the shift step sit between those two registers.
// Reset: pulse 400 us, tolerance 200 us, waiting for a preamble, code zero,
// last edge time zero, both pipeline registers empty.
// Stall: a result waits in the result register while out_o.ready is low; the
// input register takes one more word if it is empty, then in_i.ready drops
// until the result drains.
`default_nettype none

module rf_remote_pulse_decoder_unit #(
  parameter int unsigned CODE_BITS = rrpd_pkg::CODE_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rrpd_in_if.sink    in_i,
  rrpd_out_if.source out_o,
  rrpd_cfg_if.sink   cfg_i
);
  import rrpd_pkg::*;

  cfg_t            cfg_q, cfg_d;
  logic            s1_valid;
  in_word_t        s1_word;
  logic            take;
  logic [TS_W-1:0] interval;
  match_t          match;

  // Write configuration registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == REG_PULSE) begin
        cfg_d.pulse_us = cfg_i.data;
      end else if (cfg_i.index == REG_TOL) begin
        cfg_d.tolerance_us = cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pulse_us: PULSE_RST, tolerance_us: TOL_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rrpd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (s1_valid),
    .word_o  (s1_word)
  );

  rrpd_match u_match (
    .interval_i (interval),
    .cfg_i      (cfg_q),
    .match_o    (match)
  );

  rrpd_core #(
    .CODE_BITS (CODE_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid),
    .word_i     (s1_word),
    .take_o     (take),
    .interval_o (interval),
    .match_i    (match),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rrpd_pkg::*;

  // Index outside the register map, written once to check it is dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam int unsigned N_SETTINGS = 9;

  typedef enum logic [1:0] {
    RX_HUNT,
    RX_FIRST,
    RX_SECOND,
    RX_HELD
  } rx_phase_e;

  typedef struct packed {
    logic                  held;
    logic [CODE_OUT_W-1:0] code;
  } code_word_t;

  logic clk_i;
  logic rst_ni;

  rrpd_in_if  in_if ();
  rrpd_out_if out_if ();
  rrpd_cfg_if cfg_if ();

  rf_remote_pulse_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Decoder mirror: registers and receive state
  logic [CFG_W-1:0]      dec_pulse;
  logic [CFG_W-1:0]      dec_tol;
  rx_phase_e             dec_phase;
  logic [TS_W-1:0]       dec_last_ts;
  logic [HP_W-1:0]       dec_half;
  logic [4:0]            dec_bits;
  logic [CODE_OUT_W-1:0] dec_shift;

  code_word_t code_q[$];
  in_word_t   word_q[$];

  int          err_count;
  int          tx_gap;
  int          rx_hold;
  int          words_out;
  bit          tx_quiet;
  bit          rx_quiet;
  int          gen_pulse;
  int          gen_tol;
  logic [TS_W-1:0] ts_cursor;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Interval within tolerance of mult unit pulses
  function automatic logic is_near(logic [TS_W-1:0] span, int unsigned mult);
    logic [TS_W-1:0] nominal;
    logic [TS_W-1:0] dev;
    nominal = TS_W'(dec_pulse) * TS_W'(mult);
    dev     = (span >= nominal) ? span - nominal : nominal - span;
    return dev < TS_W'(dec_tol);
  endfunction

  // Advance the receive state by one word and queue the code it shows
  task automatic decode_word(in_word_t w);
    logic [TS_W-1:0] span;
    logic            took;
    took = 1'b1;
    if (w.cmd == CMD_CLEAR) begin
      dec_shift = '0;
      dec_phase = RX_HUNT;
    end else begin
      span        = w.timestamp_us - dec_last_ts;
      dec_last_ts = w.timestamp_us;
      case (dec_phase)
        RX_HUNT: begin
          if (is_near(span, PREAMBLE_MULT)) begin
            dec_shift = '0;
            dec_bits  = '0;
            dec_phase = RX_FIRST;
          end
        end
        RX_FIRST: begin
          if (is_near(span, LONG_MULT)) begin
            dec_half  = HP_LONG_MARK;
            dec_phase = RX_SECOND;
          end else if (is_near(span, SHORT_MULT)) begin
            dec_half  = HP_SHORT_MARK;
            dec_phase = RX_SECOND;
          end else begin
            dec_phase = RX_HUNT;
          end
        end
        RX_SECOND: begin
          if (is_near(span, LONG_MULT)) dec_half = dec_half + HP_LONG_INC;
          else if (is_near(span, SHORT_MULT)) dec_half = dec_half + HP_SHORT_INC;
          else took = 1'b0;
          if (!took) begin
            dec_phase = RX_HUNT;
          end else if (dec_half == HP_BIT_ZERO || dec_half == HP_BIT_ONE) begin
            dec_shift = {dec_shift[CODE_OUT_W-2:0], dec_half == HP_BIT_ONE};
            dec_bits  = dec_bits + 5'd1;
            dec_phase = (dec_bits == CODE_BITS_DEF) ? RX_HELD : RX_FIRST;
          end else begin
            dec_phase = RX_HUNT;
          end
        end
        default: ;
      endcase
    end
    code_q.push_back('{held: dec_phase == RX_HELD, code: dec_shift});
  endtask

  // Track register writes and accepted words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == REG_PULSE) dec_pulse = cfg_if.data;
        else if (cfg_if.index == REG_TOL) dec_tol = cfg_if.data;
      end
      if (in_if.valid && in_if.ready) begin
        decode_word('{cmd: in_if.cmd, timestamp_us: in_if.timestamp_us});
      end
    end
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer pending words, holding each until taken
  always @(posedge clk_i) begin : drive_in
    in_word_t nxt;
    if (rst_ni && (!in_if.valid || in_if.ready)) begin
      if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        in_if.valid <= 1'b0;
      end else if (word_q.size() != 0) begin
        nxt = word_q.pop_front();
        in_if.valid        <= 1'b1;
        in_if.cmd          <= nxt.cmd;
        in_if.timestamp_us <= nxt.timestamp_us;
        tx_gap = pick_gap(tx_quiet);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Compare result words and pace the output ready
  always @(posedge clk_i) begin : watch_out
    code_word_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        words_out++;
        if (code_q.size() == 0) begin
          $error("result word with no expectation waiting");
          err_count++;
        end else begin
          want = code_q.pop_front();
          if (out_if.code_ready !== want.held) begin
            $error("code_ready: expected %0d, got %0d", want.held, out_if.code_ready);
            err_count++;
          end
          if (out_if.code_value !== want.code) begin
            $error("code_value: expected %06h, got %06h", want.code, out_if.code_value);
            err_count++;
          end
        end
        // Hold off for a long stretch now and then so the input backs up
        if (words_out % 500 == 200) rx_hold = 300;
      end
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        out_if.ready <= 1'b0;
      end else begin
        rx_hold = pick_gap(rx_quiet);
        out_if.ready <= (rx_hold == 0);
      end
    end
  end

  task automatic push_at(logic op, logic [TS_W-1:0] stamp);
    word_q.push_back('{cmd: op, timestamp_us: stamp});
  endtask

  task automatic push_edge(int span);
    ts_cursor = ts_cursor + TS_W'(span);
    push_at(CMD_EDGE, ts_cursor);
  endtask

  // Nominal interval with deviation inside the tolerance, edges favored
  function automatic int jittered(int mult);
    int spread;
    int r;
    spread = (gen_tol > 0) ? gen_tol - 1 : 0;
    r      = $urandom_range(0, 9);
    if (r == 0) return gen_pulse * mult + spread;
    if (r == 1) return gen_pulse * mult - spread;
    return gen_pulse * mult + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // Quiet line, preamble, then two intervals per bit, MSB first
  task automatic push_frame(logic [CODE_OUT_W-1:0] code, bit corrupt);
    int  bad_at;
    int  k;
    int  span;
    int  mult;
    logic bit_val;
    logic long_half;
    bad_at = corrupt ? int'($urandom_range(0, 2 * CODE_OUT_W)) : -1;
    push_edge($urandom_range(40000, 400000));
    for (k = 0; k <= 2 * CODE_OUT_W; k++) begin
      if (k == 0) begin
        mult = PREAMBLE_MULT;
      end else begin
        bit_val   = code[CODE_OUT_W - 1 - (k - 1) / 2];
        long_half = bit_val ^ ((k - 1) % 2 == 1);
        mult      = long_half ? LONG_MULT : SHORT_MULT;
      end
      span = jittered(mult);
      if (k == bad_at) begin
        case ($urandom_range(0, 2))
          0: span = jittered((mult == LONG_MULT) ? SHORT_MULT : LONG_MULT);
          1: span = gen_pulse * mult + (($urandom_range(0, 1) == 1) ? gen_tol : -gen_tol);
          default: span = $urandom_range(0, 100000);
        endcase
      end
      push_edge(span);
    end
  endtask

  // Usually drop a held code with a clear word, sometimes after a few edges that must be ignored
  task automatic push_tail();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r >= 70 && r < 90) begin
      for (k = 0; k < int'($urandom_range(1, 3)); k++) push_edge(jittered(LONG_MULT));
    end
    if (r < 90) push_at(CMD_CLEAR, $urandom);
  endtask

  task automatic push_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      ts_cursor = $urandom;
      push_at(CMD_EDGE, ts_cursor);
    end else if (r < 70) begin
      push_at(CMD_CLEAR, $urandom);
    end else begin
      case ($urandom_range(0, 2))
        0: push_edge(jittered(SHORT_MULT));
        1: push_edge(jittered(LONG_MULT));
        default: push_edge(jittered(PREAMBLE_MULT));
      endcase
    end
  endtask

  task automatic push_phase(int frames);
    int f;
    int k;
    int r;
    logic [CODE_OUT_W-1:0] code;
    for (f = 0; f < frames; f++) begin
      r = $urandom_range(0, 99);
      if (r < 10) code = '0;
      else if (r < 20) code = '1;
      else code = CODE_OUT_W'($urandom);
      push_frame(code, $urandom_range(0, 99) < 15);
      push_tail();
      for (k = 0; k < int'($urandom_range(2, 6)); k++) push_noise();
    end
  endtask

  // Wait for every word taken and every result seen, then drain the pipe
  task automatic wait_idle();
    while (word_q.size() != 0 || in_if.valid || code_q.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_W'(val);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    if (idx == REG_PULSE) gen_pulse = val;
    else if (idx == REG_TOL) gen_tol = val;
  endtask

  initial begin : stimulus
    int pulse_set [N_SETTINGS];
    int tol_set [N_SETTINGS];
    int i;
    pulse_set = '{1, 4095, 4095, 100, 0, 50, -1, -1, 400};
    tol_set   = '{1, 4095, 1, 300, 50, 0, -1, -1, 200};

    in_if.valid        = 1'b0;
    in_if.cmd          = CMD_EDGE;
    in_if.timestamp_us = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_PULSE;
    cfg_if.data        = '0;
    rst_ni             = 1'b0;
    err_count = 0;
    tx_gap    = 0;
    rx_hold   = 0;
    words_out = 0;
    tx_quiet  = 1'b0;
    rx_quiet  = 1'b0;
    dec_pulse   = PULSE_RST;
    dec_tol     = TOL_RST;
    dec_phase   = RX_HUNT;
    dec_last_ts = '0;
    dec_half    = '0;
    dec_bits    = '0;
    dec_shift   = '0;
    gen_pulse   = PULSE_RST;
    gen_tol     = TOL_RST;
    ts_cursor   = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: timestamp extremes, wrap, both bit values, aborts, tolerance edge
    push_at(CMD_EDGE, '0);
    push_at(CMD_EDGE, '1);
    push_at(CMD_CLEAR, '1);
    ts_cursor = '1;
    push_edge(2400);
    push_edge(599);
    push_edge(1200);
    push_edge(1001);
    push_edge(400);
    push_edge(400);
    push_edge(400);
    push_edge(2599);
    push_edge(1200);
    push_edge(1399);
    push_edge(2200);
    push_edge(2600);
    push_edge(2400);
    push_edge(800);
    push_edge(2400);
    push_edge(201);
    push_edge(5000);
    push_edge(2400);
    push_edge(1200);
    push_edge(400);
    push_at(CMD_CLEAR, '0);
    ts_cursor = '0;
    push_at(CMD_EDGE, ts_cursor);
    push_phase(3);
    wait_idle();

    // Random frames under a range of settings, extremes included
    for (i = 0; i < N_SETTINGS; i++) begin
      write_reg(REG_PULSE, (pulse_set[i] < 0) ? int'($urandom_range(1, 4095)) : pulse_set[i]);
      write_reg(REG_TOL, (tol_set[i] < 0) ? int'($urandom_range(1, 4095)) : tol_set[i]);
      if (i == 2) write_reg(REG_SPARE, $urandom_range(0, 4095));
      if (i == 3) ts_cursor = 32'hFFFF_0000;
      tx_quiet = (i % 4 == 1);
      rx_quiet = (i % 4 == 1);
      @(negedge clk_i);
      push_phase(2);
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (code_q.size() != 0) begin
      $error("%0d expected result words never arrived", code_q.size());
      err_count++;
    end
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
